// File: rtl/event_timer_one_shot_top_macros.svh
// Assertion macros used by the event timer top level.
// Depends on nothing; expects aclk and aresetn to exist in the including module.
`ifndef EVENT_TIMER_ONE_SHOT_TOP_MACROS_SVH
`define EVENT_TIMER_ONE_SHOT_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ETOS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("event timer check failed");

// Next-cycle implication, checked outside reset.
`define ETOS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("event timer check failed");

`endif

// File: rtl/etos_pkg.sv
// Package for the single-timer event timer: constants, register offsets and
// the word types passed between the top level and the register core.
package etos_pkg;

    // Width of the main counter and comparator (32 to 64).
    localparam int COUNT_BITS = 64;
    localparam bit WIDE_COUNTER = (COUNT_BITS == 64);

    localparam int CMD_BITS = 2;
    localparam int ADDR_BITS = 9;
    localparam int DATA_BITS = 64;

    // Commands.
    localparam logic [CMD_BITS-1:0] CMD_READ = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_TICK = 2'd2;

    // Register offsets (bytes).
    localparam logic [ADDR_BITS-1:0] OFF_CAPS = 9'h000;
    localparam logic [ADDR_BITS-1:0] OFF_GCONF = 9'h010;
    localparam logic [ADDR_BITS-1:0] OFF_COUNT = 9'h0f0;
    localparam logic [ADDR_BITS-1:0] OFF_TCONF = 9'h100;
    localparam logic [ADDR_BITS-1:0] OFF_TCOMP = 9'h108;
    localparam logic [ADDR_BITS-1:0] TIMER_STRIDE = 9'h020;
    localparam logic [ADDR_BITS-1:0] TIMER_IDX = 9'd0;
    localparam logic [ADDR_BITS-1:0] OFF_T0_CONF = OFF_TCONF + TIMER_IDX * TIMER_STRIDE;
    localparam logic [ADDR_BITS-1:0] OFF_T0_COMP = OFF_TCOMP + TIMER_IDX * TIMER_STRIDE;

    // Configuration register indexes and widths.
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PERIOD = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_VENDOR = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REVISION = 2'd2;
    localparam int PERIOD_BITS = 27;
    localparam int VENDOR_BITS = 16;
    localparam int REVISION_BITS = 8;
    localparam int CFG_DATA_BITS = 27;
    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 27'd69841279;
    localparam logic [REVISION_BITS-1:0] REVISION_RESET = 8'd1;

    // Timer configuration bits.
    localparam int TSET_BITS = 16;
    localparam logic [TSET_BITS-1:0] TSET_WRITABLE = 16'h7f4e;
    localparam int TSET_INT_ENABLE_BIT = 2;
    localparam int TSET_SIZE_CAP_BIT = 5;

    // Stream word widths, padded to whole bytes.
    localparam int S_TDATA_BITS = 80;
    localparam int M_TDATA_BITS = 72;

    typedef struct packed {
        logic                  valid;
        logic [CMD_BITS-1:0]   cmd;
        logic [ADDR_BITS-1:0]  addr;
        logic [DATA_BITS-1:0]  wdata;
    } etos_op_t;

    typedef struct packed {
        logic [DATA_BITS-1:0]  read_data;
        logic                  irq_pulse;
        logic                  counting;
    } etos_res_t;

endpackage

// File: rtl/event_timer_one_shot_top.sv
// Top level of the single-timer event timer: input stage, result stage and
// the register core. Depends on etos_pkg, etos_core and the assertion macros.
//
// Usage. Each word on the slave channel is one operation: a register read, a
// register write or one counter clock tick, selected by s_tuser. Every word
// gives exactly one result word on the master channel, carrying the read
// value (zero for writes and ticks), an interrupt flag raised when a
// tick brings the counter onto the comparator with interrupts enabled, and
// the current global enable bit.
// From acceptance, a word is held in the input register, then passes through
// the register core into the result register, which offers it. Throughput is
// one word per cycle while the receiver takes results; the counter increment
// and comparator match are a single 64-bit add and compare in the core. When
// the receiver stalls, the result register holds its word, the input register
// may still take one further word, and s_tready then falls until the result
// is taken. The identification registers (period, vendor, revision) are
// written through the cfg port while the block is idle, a rule for the user
// that the block does not enforce. Reset (aresetn low, synchronous) empties
// both stages, clears the counter, enables and timer settings, sets the
// comparator to all ones and restores the identification defaults.
`include "event_timer_one_shot_top_macros.svh"

module event_timer_one_shot_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Slave channel.
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // tdata: address [8:0], write_data [72:9], zero padding [79:73]
    input  logic [etos_pkg::S_TDATA_BITS-1:0]     s_tdata,
    // tuser: command [1:0]
    input  logic [etos_pkg::CMD_BITS-1:0]         s_tuser,
    // Master channel.
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // tdata: read_data [63:0], irq_pulse [64], counting [65], zero padding [71:66]
    output logic [etos_pkg::M_TDATA_BITS-1:0]     m_tdata,
    // Configuration write port.
    input  logic                                  cfg_wr_en,
    input  logic [etos_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [etos_pkg::CFG_DATA_BITS-1:0]    cfg_wr_data
);

    localparam int RES_BITS = $bits(etos_pkg::etos_res_t);

    logic                                 in_valid_reg;
    logic [etos_pkg::CMD_BITS-1:0]        in_cmd_reg;
    logic [etos_pkg::ADDR_BITS-1:0]       in_addr_reg;
    logic [etos_pkg::DATA_BITS-1:0]       in_data_reg;

    logic                                 m_valid_reg;
    etos_pkg::etos_res_t                  m_res_reg;

    logic                                 advance;
    logic                                 s_take;
    etos_pkg::etos_op_t                   op;
    etos_pkg::etos_res_t                  res;

    // The input word moves on whenever the result register is empty or its
    // word is being taken in this cycle.
    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    assign op.valid = in_valid_reg && advance;
    assign op.cmd   = in_cmd_reg;
    assign op.addr  = in_addr_reg;
    assign op.wdata = in_data_reg;

    etos_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .op          (op),
        .res         (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                m_valid_reg <= in_valid_reg;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_cmd_reg  <= s_tuser;
            in_addr_reg <= s_tdata[etos_pkg::ADDR_BITS-1:0];
            in_data_reg <= s_tdata[etos_pkg::ADDR_BITS +: etos_pkg::DATA_BITS];
        end
        if (op.valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(etos_pkg::M_TDATA_BITS - RES_BITS){1'b0}},
                       m_res_reg.counting, m_res_reg.irq_pulse, m_res_reg.read_data};

    // An interrupt can only come from a tick taken while counting is enabled.
    `ETOS_ASSERT_NOW(a_irq_needs_enable, m_valid_reg && m_res_reg.irq_pulse, m_res_reg.counting)
    // A word leaving the input stage always lands in the result register.
    `ETOS_ASSERT_NEXT(a_stage_moves, in_valid_reg && advance, m_valid_reg)
    // Back-pressure only arises with the input stage occupied behind a stall.
    `ETOS_ASSERT_NOW(a_stall_cause, !s_tready, in_valid_reg && m_valid_reg && !m_tready)

endmodule

// File: rtl/etos_core.sv
// Register core of the event timer: holds the counter, comparator, settings
// and identification registers, and computes one result per operation.
// Depends on etos_pkg.
module etos_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [etos_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [etos_pkg::CFG_DATA_BITS-1:0]    cfg_wr_data,
    input  etos_pkg::etos_op_t                    op,
    output etos_pkg::etos_res_t                   res
);

    logic [etos_pkg::PERIOD_BITS-1:0]   period_reg;
    logic [etos_pkg::VENDOR_BITS-1:0]   vendor_reg;
    logic [etos_pkg::REVISION_BITS-1:0] revision_reg;

    logic [etos_pkg::COUNT_BITS-1:0]    count_reg, count_next;
    logic [etos_pkg::COUNT_BITS-1:0]    compare_reg, compare_next;
    logic [etos_pkg::TSET_BITS-1:0]     tset_reg, tset_next;
    logic                               enable_reg, enable_next;
    logic                               legacy_reg, legacy_next;

    logic [etos_pkg::COUNT_BITS-1:0]    count_inc;
    logic [etos_pkg::DATA_BITS-1:0]     rd_value;
    logic                               irq;

    assign count_inc = count_reg + etos_pkg::COUNT_BITS'(1);

    // Register read multiplexer; unmapped offsets read zero.
    always_comb begin
        case (op.addr)
            etos_pkg::OFF_CAPS: begin
                rd_value = {5'd0, period_reg, vendor_reg, 1'b1, 1'b0,
                            etos_pkg::WIDE_COUNTER, 5'd0, revision_reg};
            end
            etos_pkg::OFF_GCONF: begin
                rd_value = {62'd0, legacy_reg, enable_reg};
            end
            etos_pkg::OFF_COUNT: begin
                rd_value = etos_pkg::DATA_BITS'(count_reg);
            end
            etos_pkg::OFF_T0_CONF: begin
                rd_value = etos_pkg::DATA_BITS'(tset_reg);
                rd_value[etos_pkg::TSET_SIZE_CAP_BIT] = etos_pkg::WIDE_COUNTER;
            end
            etos_pkg::OFF_T0_COMP: begin
                rd_value = etos_pkg::DATA_BITS'(compare_reg);
            end
            default: begin
                rd_value = '0;
            end
        endcase
    end

    always_comb begin
        count_next   = count_reg;
        compare_next = compare_reg;
        tset_next    = tset_reg;
        enable_next  = enable_reg;
        legacy_next  = legacy_reg;
        irq          = 1'b0;
        res.read_data = '0;
        if (op.valid) begin
            case (op.cmd)
                etos_pkg::CMD_READ: begin
                    res.read_data = rd_value;
                end
                etos_pkg::CMD_WRITE: begin
                    case (op.addr)
                        etos_pkg::OFF_GCONF: begin
                            enable_next = op.wdata[0];
                            legacy_next = op.wdata[1];
                        end
                        etos_pkg::OFF_COUNT: begin
                            count_next = op.wdata[etos_pkg::COUNT_BITS-1:0];
                        end
                        etos_pkg::OFF_T0_CONF: begin
                            tset_next = op.wdata[etos_pkg::TSET_BITS-1:0]
                                        & etos_pkg::TSET_WRITABLE;
                        end
                        etos_pkg::OFF_T0_COMP: begin
                            compare_next = op.wdata[etos_pkg::COUNT_BITS-1:0];
                        end
                        default: begin
                        end
                    endcase
                end
                etos_pkg::CMD_TICK: begin
                    if (enable_reg) begin
                        count_next = count_inc;
                        irq = tset_reg[etos_pkg::TSET_INT_ENABLE_BIT]
                              && (count_inc == compare_reg);
                    end
                end
                default: begin
                end
            endcase
        end
        res.irq_pulse = irq;
        res.counting  = enable_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            compare_reg  <= '1;
            tset_reg     <= '0;
            enable_reg   <= 1'b0;
            legacy_reg   <= 1'b0;
            period_reg   <= etos_pkg::PERIOD_RESET;
            vendor_reg   <= '0;
            revision_reg <= etos_pkg::REVISION_RESET;
        end else begin
            count_reg   <= count_next;
            compare_reg <= compare_next;
            tset_reg    <= tset_next;
            enable_reg  <= enable_next;
            legacy_reg  <= legacy_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    etos_pkg::CFG_PERIOD: begin
                        period_reg <= cfg_wr_data[etos_pkg::PERIOD_BITS-1:0];
                    end
                    etos_pkg::CFG_VENDOR: begin
                        vendor_reg <= cfg_wr_data[etos_pkg::VENDOR_BITS-1:0];
                    end
                    etos_pkg::CFG_REVISION: begin
                        revision_reg <= cfg_wr_data[etos_pkg::REVISION_BITS-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the single-timer event timer block.
// Depends on etos_pkg and event_timer_one_shot_top; holds its own timer predictor.

module tb_top;
    import etos_pkg::*;

    // The command field has one spare code that must do nothing.
    localparam logic [CMD_BITS-1:0] CMD_SPARE = 2'd3;
    localparam logic [DATA_BITS-1:0] COUNT_MASK =
        {DATA_BITS{1'b1}} >> (DATA_BITS - COUNT_BITS);
    localparam int IDLE_LIMIT = 1000;
    localparam int RANDOM_WORDS = 1600;
    localparam int PHASES = 5;
    localparam int REPORT_LIMIT = 10;

    // The scoreboard mirrors the timer registers. Each accepted input word
    // updates the mirror and queues the result word that it must produce;
    // each accepted result word is compared with the oldest queued one.
    class timer_scoreboard;
        logic [DATA_BITS-1:0]     main_count;
        logic [DATA_BITS-1:0]     compare_value;
        logic                     global_enable;
        logic                     legacy_route;
        logic [TSET_BITS-1:0]     timer_settings;
        logic [PERIOD_BITS-1:0]   period_fs;
        logic [VENDOR_BITS-1:0]   vendor;
        logic [REVISION_BITS-1:0] revision;
        etos_res_t                due_results[$];
        int                       mismatches;
        int                       checked;
        int                       pulses;

        function new();
            main_count = '0;
            compare_value = COUNT_MASK;
            global_enable = 1'b0;
            legacy_route = 1'b0;
            timer_settings = '0;
            period_fs = PERIOD_RESET;
            vendor = '0;
            revision = REVISION_RESET;
            mismatches = 0;
            checked = 0;
            pulses = 0;
        endfunction

        function void set_register(logic [CFG_IDX_BITS-1:0] idx,
                                   logic [CFG_DATA_BITS-1:0] value);
            case (idx)
                CFG_PERIOD:   period_fs = value[PERIOD_BITS-1:0];
                CFG_VENDOR:   vendor = value[VENDOR_BITS-1:0];
                CFG_REVISION: revision = value[REVISION_BITS-1:0];
                default: ;
            endcase
        endfunction

        function logic [DATA_BITS-1:0] register_value(logic [ADDR_BITS-1:0] addr);
            logic [DATA_BITS-1:0] value;
            value = '0;
            case (addr)
                OFF_CAPS: begin
                    value[7:0] = revision;
                    value[13] = WIDE_COUNTER;
                    value[15] = 1'b1;
                    value[31:16] = vendor;
                    value[32 +: PERIOD_BITS] = period_fs;
                end
                OFF_GCONF: begin
                    value[0] = global_enable;
                    value[1] = legacy_route;
                end
                OFF_COUNT:   value = main_count;
                OFF_T0_CONF: begin
                    value[TSET_BITS-1:0] = timer_settings;
                    value[TSET_SIZE_CAP_BIT] = WIDE_COUNTER;
                end
                OFF_T0_COMP: value = compare_value;
                default: ;
            endcase
            return value;
        endfunction

        function void note_input(logic [CMD_BITS-1:0] cmd, logic [ADDR_BITS-1:0] addr,
                                 logic [DATA_BITS-1:0] wdata);
            etos_res_t res;
            res = '0;
            case (cmd)
                CMD_READ: res.read_data = register_value(addr);
                CMD_WRITE: begin
                    case (addr)
                        OFF_GCONF: begin
                            global_enable = wdata[0];
                            legacy_route = wdata[1];
                        end
                        OFF_COUNT:   main_count = wdata & COUNT_MASK;
                        OFF_T0_CONF: timer_settings = wdata[TSET_BITS-1:0] & TSET_WRITABLE;
                        OFF_T0_COMP: compare_value = wdata & COUNT_MASK;
                        default: ;
                    endcase
                end
                CMD_TICK: begin
                    if (global_enable) begin
                        main_count = (main_count + 1'b1) & COUNT_MASK;
                        if (timer_settings[TSET_INT_ENABLE_BIT] &&
                            main_count == compare_value) begin
                            res.irq_pulse = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            res.counting = global_enable;
            due_results.push_back(res);
        endfunction

        function void check_result(logic [M_TDATA_BITS-1:0] word);
            etos_res_t want;
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("Result word %h arrived with nothing expected.", word);
                end
                return;
            end
            want = due_results.pop_front();
            checked++;
            if (want.irq_pulse) begin
                pulses++;
            end
            if (word[63:0] !== want.read_data || word[64] !== want.irq_pulse ||
                word[65] !== want.counting) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("Mismatch: want read %h irq %b cnt %b, got read %h irq %b cnt %b.",
                             want.read_data, want.irq_pulse, want.counting,
                             word[63:0], word[64], word[65]);
                end
            end
        endfunction

        function int pending();
            return due_results.size();
        endfunction
    endclass

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [S_TDATA_BITS-1:0]   s_tdata;
    logic [CMD_BITS-1:0]       s_tuser;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [M_TDATA_BITS-1:0]   m_tdata;
    logic                      cfg_wr_en;
    logic [CFG_IDX_BITS-1:0]   cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_wr_data;

    timer_scoreboard sb;
    int  words_sent = 0;
    int  idle_cycles = 0;
    int  settings_used = 1;
    bit  tx_idle_on = 1'b1;
    bit  rx_idle_on = 1'b1;
    int  hold_request = 0;

    event_timer_one_shot_top i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always #1 aclk = ~aclk;

    // Both channels are sampled at the rising edge, before any of this
    // edge's assignments land, so every accepted word is seen exactly once.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
            end
            if (s_tvalid && s_tready) begin
                sb.note_input(s_tuser, s_tdata[ADDR_BITS-1:0],
                              s_tdata[ADDR_BITS +: DATA_BITS]);
            end
        end
    end

    // The watchdog ends a run that has stopped moving words.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Watchdog: no word moved for %0d cycles.", IDLE_LIMIT);
                $display("event_timer_one_shot_top test failed");
                $finish;
            end
        end
    end

    // The receiver takes results, drops tready in short random bursts, and
    // on request holds off for a long stretch so that both stages fill up
    // and the block has to stall its input.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request > 0) begin
                m_tready <= 1'b0;
                repeat (hold_request) @(posedge aclk);
                hold_request = 0;
                m_tready <= 1'b1;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offers one operation word and returns at the edge at which it is taken.
    task automatic send_word(input logic [CMD_BITS-1:0] cmd, input logic [ADDR_BITS-1:0] addr,
                             input logic [DATA_BITS-1:0] data);
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {{(S_TDATA_BITS - DATA_BITS - ADDR_BITS){1'b0}}, data, addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
    endtask

    // Waits until every expected result has come back, plus a short margin.
    // The first edge lets the monitor note the word taken just before.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_step(input logic [CFG_IDX_BITS-1:0] idx,
                            input logic [CFG_DATA_BITS-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= value;
        sb.set_register(idx, value);
        @(posedge aclk);
    endtask

    // Rewrites all three identification registers while the block is idle.
    task automatic set_identity(input logic [CFG_DATA_BITS-1:0] period,
                                input logic [CFG_DATA_BITS-1:0] vendor,
                                input logic [CFG_DATA_BITS-1:0] revision);
        cfg_step(CFG_PERIOD, period);
        cfg_step(CFG_VENDOR, vendor);
        cfg_step(CFG_REVISION, revision);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // Mostly the mapped offsets, but also unaligned and arbitrary ones.
    function automatic logic [ADDR_BITS-1:0] pick_address();
        logic [ADDR_BITS-1:0] base;
        case ($urandom_range(0, 4))
            0: base = OFF_CAPS;
            1: base = OFF_GCONF;
            2: base = OFF_COUNT;
            3: base = OFF_T0_CONF;
            default: base = OFF_T0_COMP;
        endcase
        case ($urandom_range(0, 6))
            0: return base | ADDR_BITS'($urandom_range(1, 7));
            1: return ADDR_BITS'($urandom);
            default: return base;
        endcase
    endfunction

    function automatic logic [DATA_BITS-1:0] pick_data();
        case ($urandom_range(0, 5))
            0: return '1;
            1: return '0;
            2: return DATA_BITS'($urandom_range(0, 15));
            3: return DATA_BITS'(1) << $urandom_range(0, DATA_BITS - 1);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // A well-formed run: set the counter, arm the comparator 1 to 10 ticks
    // ahead, mostly enable interrupts and counting, then send 1 to 14 ticks.
    task automatic armed_run();
        logic [DATA_BITS-1:0] base;
        logic [DATA_BITS-1:0] tconf;
        logic [DATA_BITS-1:0] gconf;
        int                   ticks;
        case ($urandom_range(0, 2))
            0: base = {$urandom, $urandom} & COUNT_MASK;
            1: base = COUNT_MASK - DATA_BITS'($urandom_range(0, 10));
            default: base = DATA_BITS'($urandom_range(0, 20));
        endcase
        tconf = {$urandom, $urandom};
        tconf[TSET_INT_ENABLE_BIT] = ($urandom_range(0, 4) != 0);
        gconf = {$urandom, $urandom};
        gconf[0] = ($urandom_range(0, 6) != 0);
        send_word(CMD_WRITE, OFF_COUNT, base);
        send_word(CMD_WRITE, OFF_T0_COMP,
                  (base + DATA_BITS'($urandom_range(1, 10))) & COUNT_MASK);
        send_word(CMD_WRITE, OFF_T0_CONF, tconf);
        send_word(CMD_WRITE, OFF_GCONF, gconf);
        ticks = $urandom_range(1, 14);
        for (int i = 0; i < ticks; i++) begin
            if ($urandom_range(0, 5) == 0) begin
                send_word(CMD_READ, OFF_COUNT, {$urandom, $urandom});
            end
            send_word(CMD_TICK, pick_address(), {$urandom, $urandom});
        end
    endtask

    // One random chunk of stimulus, weighted towards armed runs.
    task automatic random_chunk();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 10) begin
            armed_run();
        end else if (pick < 15) begin
            repeat ($urandom_range(1, 6)) begin
                send_word(CMD_BITS'($urandom_range(0, 3)), pick_address(), pick_data());
            end
        end else if (pick < 18) begin
            send_word(CMD_READ, OFF_CAPS, pick_data());
            send_word(CMD_READ, OFF_GCONF, pick_data());
            send_word(CMD_READ, OFF_COUNT, pick_data());
            send_word(CMD_READ, OFF_T0_CONF, pick_data());
            send_word(CMD_READ, OFF_T0_COMP, pick_data());
        end else begin
            send_word(CMD_WRITE, OFF_GCONF, {$urandom, $urandom} & ~DATA_BITS'(1));
            repeat ($urandom_range(1, 5)) send_word(CMD_TICK, pick_address(), pick_data());
        end
    endtask

    initial begin
        int directed_words;
        int target;
        sb = new();
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= CMD_READ;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_PERIOD;
        cfg_wr_data <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part with the reset identity: reset values of every
        // register, unmapped and unaligned offsets, a write to the read-only
        // capabilities, a tick while disabled, the counter wrapping onto a
        // zero comparator, and the spare command code.
        send_word(CMD_READ, OFF_CAPS, '0);
        send_word(CMD_READ, OFF_GCONF, '1);
        send_word(CMD_READ, OFF_COUNT, '0);
        send_word(CMD_READ, OFF_T0_CONF, '0);
        send_word(CMD_READ, OFF_T0_COMP, '0);
        send_word(CMD_READ, '1, '0);
        send_word(CMD_READ, OFF_GCONF | ADDR_BITS'(1), '0);
        send_word(CMD_WRITE, OFF_CAPS, '1);
        send_word(CMD_READ, OFF_CAPS, '0);
        send_word(CMD_TICK, OFF_CAPS, '1);
        send_word(CMD_WRITE, OFF_T0_CONF, '1);
        send_word(CMD_READ, OFF_T0_CONF, '0);
        send_word(CMD_WRITE, OFF_COUNT, '1);
        send_word(CMD_WRITE, OFF_T0_COMP, '0);
        send_word(CMD_WRITE, OFF_GCONF, '1);
        send_word(CMD_TICK, '0, '0);
        send_word(CMD_READ, OFF_COUNT, '0);
        send_word(CMD_TICK, '1, '1);
        send_word(CMD_SPARE, OFF_GCONF, '0);
        send_word(CMD_SPARE, OFF_COUNT, '1);
        send_word(CMD_WRITE, ADDR_BITS'(9'h1f8), '1);
        send_word(CMD_WRITE, OFF_GCONF, '0);
        send_word(CMD_READ, OFF_GCONF, '0);
        send_word(CMD_WRITE, OFF_T0_COMP, '1);
        send_word(CMD_READ, OFF_T0_COMP, '0);
        drain();
        directed_words = words_sent;

        // Random phases, each under its own identity setting. The first one
        // opens with a long receiver stall, the last one runs without gaps.
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: set_identity('1, '1, '1);
                1: set_identity(CFG_DATA_BITS'(1), '0, '0);
                2: set_identity(CFG_DATA_BITS'(100000000), CFG_DATA_BITS'(16'hffff),
                                CFG_DATA_BITS'(8'hff));
                default: set_identity(CFG_DATA_BITS'($urandom_range(1, 100000000)),
                                      CFG_DATA_BITS'($urandom), CFG_DATA_BITS'($urandom));
            endcase
            tx_idle_on = (phase != PHASES - 1);
            rx_idle_on = (phase != PHASES - 1);
            if (phase == 0) begin
                hold_request = 40;
            end
            send_word(CMD_READ, OFF_CAPS, '0);
            target = directed_words + (phase + 1) * RANDOM_WORDS / PHASES;
            while (words_sent < target) random_chunk();
            drain();
        end

        if (sb.pending() != 0) begin
            sb.mismatches++;
            $display("%0d expected result words never arrived.", sb.pending());
        end
        $display("Sent %0d words, %0d identity settings, %0d results checked, %0d irq pulses.",
                 words_sent, settings_used, sb.checked, sb.pulses);
        $display("Mismatches: %0d.", sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("event_timer_one_shot_top test passed");
        end else begin
            $display("event_timer_one_shot_top test failed");
        end
        $finish;
    end

endmodule
